// ===== sv/nearest_palette_color_search_macros.svh =====
// Assertion macros shared by the nearest palette color search RTL.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define NPC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define NPC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/npc_pkg.sv =====
// Shared types and constants of the nearest palette color search.
package npc_pkg;

   localparam int PIX_W   = 8;
   localparam int ENTRY_W = 3 * PIX_W;
   localparam int SQ_W    = 2 * PIX_W;
   localparam int DIST_W  = 18;
   localparam int IDX_W   = 8;
   localparam int COUNT_W = 9;
   localparam int SLOT_W  = 13;

   localparam logic [COUNT_W-1:0] ENTRIES_RESET = 9'd256;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Travels with each palette read through the distance pipeline.
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [IDX_W-1:0] idx;
   } tag_type;

endpackage

// ===== sv/npc_if.sv =====
// Request and response channel interfaces of the nearest palette color search.
interface npc_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [npc_pkg::IDX_W-1:0] entry_index;
   logic [npc_pkg::PIX_W-1:0] red;
   logic [npc_pkg::PIX_W-1:0] green;
   logic [npc_pkg::PIX_W-1:0] blue;

   modport source (output valid, op, entry_index, red, green, blue, input ready);
   modport sink (input valid, op, entry_index, red, green, blue, output ready);
endinterface

interface npc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [npc_pkg::IDX_W-1:0] match_index;

   modport source (output valid, match_index, input ready);
   modport sink (input valid, match_index, output ready);
endinterface

// ===== sv/nearest_palette_color_search.sv =====
// A load word writes one palette slot, and only when its entry_index is below
// PALETTE_ENTRIES. A query word scans palette entries 0 up to n-1, n being
// min(entries_in_use, PALETTE_ENTRIES, 256), through one palette read port and one
// squared-distance unit, one entry a cycle, and offers the lowest index at least
// distance; with n of zero the result is index 0. The block takes no new word while a
// query runs. The result sits in its own output register, so a word waiting on the
// response channel holds the block only when the next query finishes before it is taken.
`include "nearest_palette_color_search_macros.svh"

module nearest_palette_color_search #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   npc_req_if.sink                      req_chan,
   npc_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [npc_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int ADDR_W       = $clog2(PALETTE_ENTRIES);
   localparam int SEARCH_LIMIT = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   logic [npc_pkg::COUNT_W-1:0]  entries_ff;
   logic [npc_pkg::COUNT_W-1:0]  count_ff, count_in, count_new;
   logic [npc_pkg::IDX_W-1:0]    cnt_ff, cnt_in;
   logic [npc_pkg::PIX_W-1:0]    red_ff, green_ff, blue_ff;
   logic [npc_pkg::IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [npc_pkg::DIST_W-1:0]   best_dist_ff, best_dist_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [npc_pkg::IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   npc_pkg::tag_type             issue_ff, issue_in;
   npc_pkg::tag_type             dist_tag;
   logic [npc_pkg::DIST_W-1:0]   cand_dist;
   logic [npc_pkg::ENTRY_W-1:0]  rd_data;
   logic                         accept, is_query, wr_en, in_range, rd_en, empty_query;
   logic [ADDR_W-1:0]            wr_addr, rd_addr;

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_index = rsp_idx_ff;

   assign accept   = req_chan.valid && req_chan.ready;
   assign is_query = (req_chan.op == npc_pkg::OP_QUERY);
   assign in_range = ({5'b0, req_chan.entry_index}
                      < npc_pkg::SLOT_W'(PALETTE_ENTRIES));
   assign wr_en    = accept && (req_chan.op == npc_pkg::OP_LOAD) && in_range;
   assign wr_addr  = ADDR_W'({5'b0, req_chan.entry_index});
   assign rd_en    = (state_ff == ST_SCAN);
   assign rd_addr  = ADDR_W'({5'b0, cnt_ff});

   assign count_new = (entries_ff > npc_pkg::COUNT_W'(SEARCH_LIMIT))
                      ? npc_pkg::COUNT_W'(SEARCH_LIMIT) : entries_ff;
   assign empty_query = accept && is_query && (count_new == '0);

   npc_palette_ram #(
      .DEPTH  (PALETTE_ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    ({req_chan.red, req_chan.green, req_chan.blue}),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   npc_dist_unit u_dist (
      .clock       (clock),
      .reset       (reset),
      .entry       (rd_data),
      .red         (red_ff),
      .green       (green_ff),
      .blue        (blue_ff),
      .tag         (issue_ff),
      .dist_ff     (cand_dist),
      .dist_tag_ff (dist_tag)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cnt_in       = cnt_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      issue_in     = '0;

      if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               count_in = count_new;
               cnt_in   = '0;
               if (count_new == '0) begin
                  best_idx_in = '0;
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            issue_in.valid = 1'b1;
            issue_in.idx   = cnt_ff;
            issue_in.last  = ({1'b0, cnt_ff} == (count_ff - 9'd1));
            cnt_in         = cnt_ff + 8'd1;
            if (issue_in.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (dist_tag.valid && dist_tag.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The output register is free once its word leaves at this edge.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = best_idx_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Strict less-than keeps the lowest index on a tie.
      if (dist_tag.valid && ((dist_tag.idx == '0) || (cand_dist < best_dist_ff))) begin
         best_dist_in = cand_dist;
         best_idx_in  = dist_tag.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= npc_pkg::ENTRIES_RESET;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         if (csr_wr_en) begin
            entries_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      cnt_ff       <= cnt_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      rsp_idx_ff   <= rsp_idx_in;
      if (accept && is_query) begin
         red_ff   <= req_chan.red;
         green_ff <= req_chan.green;
         blue_ff  <= req_chan.blue;
      end
   end

   `NPC_ASSERT_IMP(a_dist_in_query, dist_tag.valid, state_ff != ST_IDLE, "distance outside a query")
   `NPC_ASSERT_NXT(a_last_done, dist_tag.valid && dist_tag.last, state_ff == ST_DONE, "scan did not finish")
   `NPC_ASSERT_NXT(a_empty_palette, empty_query, (state_ff == ST_DONE) && (best_idx_ff == '0), "empty palette index not 0")
   `NPC_ASSERT_IMP(a_issue_in_range, issue_ff.valid, ({1'b0, issue_ff.idx} < count_ff), "read past the search count")

endmodule

// ===== sv/npc_palette_ram.sv =====
// Palette storage: one write port and one registered read port.
module npc_palette_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [npc_pkg::ENTRY_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [npc_pkg::ENTRY_W-1:0] rd_data_ff
);

   logic [npc_pkg::ENTRY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/npc_dist_unit.sv =====
// Two-stage squared distance unit, one palette entry per cycle.
module npc_dist_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [npc_pkg::ENTRY_W-1:0] entry,
   input  logic [npc_pkg::PIX_W-1:0]   red,
   input  logic [npc_pkg::PIX_W-1:0]   green,
   input  logic [npc_pkg::PIX_W-1:0]   blue,
   input  npc_pkg::tag_type            tag,
   output logic [npc_pkg::DIST_W-1:0]  dist_ff,
   output npc_pkg::tag_type            dist_tag_ff
);

   function automatic logic [npc_pkg::PIX_W-1:0] abs_diff(
      input logic [npc_pkg::PIX_W-1:0] a,
      input logic [npc_pkg::PIX_W-1:0] b
   );
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [npc_pkg::PIX_W-1:0] dr, dg, db;
   logic [npc_pkg::SQ_W-1:0]  sq_r_ff, sq_g_ff, sq_b_ff;
   logic [npc_pkg::SQ_W-1:0]  sq_r_in, sq_g_in, sq_b_in;
   npc_pkg::tag_type          sq_tag_ff;

   always_comb begin
      dr = abs_diff(entry[23:16], red);
      dg = abs_diff(entry[15:8], green);
      db = abs_diff(entry[7:0], blue);
      sq_r_in = dr * dr;
      sq_g_in = dg * dg;
      sq_b_in = db * db;
   end

   always_ff @(posedge clock) begin
      sq_r_ff <= sq_r_in;
      sq_g_ff <= sq_g_in;
      sq_b_ff <= sq_b_in;
      dist_ff <= npc_pkg::DIST_W'(sq_r_ff) + npc_pkg::DIST_W'(sq_g_ff)
               + npc_pkg::DIST_W'(sq_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_tag_ff   <= '0;
         dist_tag_ff <= '0;
      end else begin
         sq_tag_ff   <= tag;
         dist_tag_ff <= sq_tag_ff;
      end
   end

endmodule
